@@ hdl/dcd_pkg.sv @@
// Shared types, constants and month tables for the calendar date distance unit.
package dcd_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned DN_W     = 23;
  localparam int unsigned DIST_W   = 22;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned CUM_W    = 9;
  localparam int unsigned QH_W     = 8;
  localparam int unsigned Q7_W     = 21;
  localparam int unsigned NDAY_W   = 8;

  localparam int unsigned LANE_STAGES = 4;

  // op bit positions
  localparam int unsigned OP_NTH_A_BIT = 1;
  localparam int unsigned OP_NTH_B_BIT = 0;

  // reciprocal constants: floor(x/100) = (x*5243)>>19 for x < 2^14,
  // floor(x/7) = (x*9586981)>>26 for x < 2^23
  localparam int unsigned RECIP100    = 5243;
  localparam int unsigned RECIP100_SH = 19;
  localparam int unsigned RECIP7      = 9586981;
  localparam int unsigned RECIP7_SH   = 26;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [WDAY_W-1:0]  WDAY_SAT  = 3'd6;
  localparam logic [LEN_W-1:0]   LEAP_FEB_LEN = 5'd29;

  typedef struct packed {
    logic               nth;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
  } date_t;

  typedef struct packed {
    logic            ok;
    logic [DN_W-1:0] dn;
  } lane_res_t;

  // days before month m in a common year
  function automatic logic [CUM_W-1:0] month_cum(logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] month_len(logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    return 5'd28;
      4'd4:    return 5'd30;
      4'd6:    return 5'd30;
      4'd9:    return 5'd30;
      4'd11:   return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

endpackage

@@ hdl/dcd_if.sv @@
// Valid/ready channel interfaces for date pairs in and distances out.
interface dcd_in_if;
  import dcd_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [YEAR_W-1:0]  year_a;
  logic [MONTH_W-1:0] month_a;
  logic [DAY_W-1:0]   day_a;
  logic [WDAY_W-1:0]  weekday_a;
  logic [YEAR_W-1:0]  year_b;
  logic [MONTH_W-1:0] month_b;
  logic [DAY_W-1:0]   day_b;
  logic [WDAY_W-1:0]  weekday_b;

  modport source (
    output valid, op, year_a, month_a, day_a, weekday_a,
           year_b, month_b, day_b, weekday_b,
    input  ready
  );
  modport sink (
    input  valid, op, year_a, month_a, day_a, weekday_a,
           year_b, month_b, day_b, weekday_b,
    output ready
  );
endinterface

interface dcd_out_if;
  import dcd_pkg::*;
  logic              valid;
  logic              ready;
  logic              invalid;
  logic [DIST_W-1:0] day_distance;

  modport source (output valid, invalid, day_distance, input ready);
  modport sink (input valid, invalid, day_distance, output ready);
endinterface

@@ hdl/dcd_lane.sv @@
// One date lane: checks a date and turns it into a day number over four stages.
module dcd_lane #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  dcd_pkg::date_t    date_i,
  output dcd_pkg::lane_res_t res_o
);
  import dcd_pkg::*;

  // stage 1: year bounds, field checks, divisions by 100
  logic [YEAR_W-1:0]           p_c;
  logic [YEAR_W+13-1:0]        prod_p_c, prod_y_c;
  logic                        ok1_c;

  logic [YEAR_W-1:0]  p_q, y1_q;
  logic [QH_W-1:0]    qp_q, qy_q;
  logic [MONTH_W-1:0] m1_q;
  logic [DAY_W-1:0]   d1_q;
  logic [WDAY_W-1:0]  w1_q;
  logic               nth1_q, ok1_q;

  always_comb begin
    p_c      = date_i.year - YEAR_W'(1);
    prod_p_c = (YEAR_W+13)'(p_c) * (YEAR_W+13)'(RECIP100);
    prod_y_c = (YEAR_W+13)'(date_i.year) * (YEAR_W+13)'(RECIP100);
    ok1_c    = (date_i.year != '0) && (32'(date_i.year) <= MAX_YEAR) &&
               (date_i.month >= MONTH_JAN) && (date_i.month <= MONTH_DEC) &&
               (date_i.day != '0) && (!date_i.nth || (date_i.weekday <= WDAY_SAT));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_c;
      y1_q   <= date_i.year;
      qp_q   <= QH_W'(prod_p_c >> RECIP100_SH);
      qy_q   <= QH_W'(prod_y_c >> RECIP100_SH);
      m1_q   <= date_i.month;
      d1_q   <= date_i.day;
      w1_q   <= date_i.weekday;
      nth1_q <= date_i.nth;
      ok1_q  <= ok1_c;
    end
  end

  // stage 2: leap rule, start of month, month length
  logic [DN_W-1:0]  ystart_c, first2_c;
  logic             hundred_c, leap_c, feb_adj_c;
  logic [LEN_W-1:0] len2_c;

  logic [DN_W-1:0]  first2_q;
  logic [LEN_W-1:0] len2_q;
  logic [DAY_W-1:0] d2_q;
  logic [WDAY_W-1:0] w2_q;
  logic             nth2_q, ok2_q;

  always_comb begin
    ystart_c  = DN_W'(p_q) * DN_W'(365) + DN_W'(p_q >> 2) - DN_W'(qp_q) + DN_W'(qp_q >> 2);
    hundred_c = (y1_q == YEAR_W'(YEAR_W'(qy_q) * YEAR_W'(100)));
    leap_c    = hundred_c ? (qy_q[1:0] == 2'd0) : (y1_q[1:0] == 2'd0);
    feb_adj_c = leap_c && (m1_q > MONTH_FEB);
    first2_c  = ystart_c + DN_W'(month_cum(m1_q)) + DN_W'(feb_adj_c);
    len2_c    = (leap_c && (m1_q == MONTH_FEB)) ? LEAP_FEB_LEN : month_len(m1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first2_q <= first2_c;
      len2_q   <= len2_c;
      d2_q     <= d1_q;
      w2_q     <= w1_q;
      nth2_q   <= nth1_q;
      ok2_q    <= ok1_q;
    end
  end

  // stage 3: quotient of (first + 1) by 7 for the weekday of the 1st
  logic [DN_W+24-1:0] prod7_c;

  logic [DN_W-1:0]  first3_q;
  logic [Q7_W-1:0]  q7_q;
  logic [LEN_W-1:0] len3_q;
  logic [DAY_W-1:0] d3_q;
  logic [WDAY_W-1:0] w3_q;
  logic             nth3_q, ok3_q;

  always_comb begin
    prod7_c = (DN_W+24)'(first2_q + DN_W'(1)) * (DN_W+24)'(RECIP7);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first3_q <= first2_q;
      q7_q     <= Q7_W'(prod7_c >> RECIP7_SH);
      len3_q   <= len2_q;
      d3_q     <= d2_q;
      w3_q     <= w2_q;
      nth3_q   <= nth2_q;
      ok3_q    <= ok2_q;
    end
  end

  // stage 4: day within month, length check, day number
  logic [DN_W-1:0]   rem_full_c;
  logic [2:0]        wd1_c;
  logic [3:0]        t_c;
  logic [2:0]        off_c;
  logic [NDAY_W-1:0] nday_c, day_c;
  logic              ok4_c;
  lane_res_t         res_q;

  always_comb begin
    rem_full_c = first3_q + DN_W'(1) - DN_W'(q7_q) * DN_W'(7);
    wd1_c      = rem_full_c[2:0];
    t_c        = 4'(w3_q) + 4'd7 - 4'(wd1_c);
    off_c      = (t_c >= 4'd7) ? 3'(t_c - 4'd7) : 3'(t_c);
    nday_c     = NDAY_W'(1) + NDAY_W'(off_c) + NDAY_W'(7) * (NDAY_W'(d3_q) - NDAY_W'(1));
    day_c      = nth3_q ? nday_c : NDAY_W'(d3_q);
    ok4_c      = ok3_q && (day_c <= NDAY_W'(len3_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.ok <= ok4_c;
      res_q.dn <= first3_q + DN_W'(day_c) - DN_W'(1);
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/dcd_merge.sv @@
// Merge stage: combines both lane results into validity and absolute distance.
module dcd_merge (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  dcd_pkg::lane_res_t       res_a_i,
  input  dcd_pkg::lane_res_t       res_b_i,
  output logic                     invalid_o,
  output logic [dcd_pkg::DIST_W-1:0] distance_o
);
  import dcd_pkg::*;

  logic [DN_W-1:0]   diff_c;
  logic              both_ok_c;
  logic              invalid_q;
  logic [DIST_W-1:0] distance_q;

  always_comb begin
    diff_c    = (res_a_i.dn >= res_b_i.dn) ? (res_a_i.dn - res_b_i.dn)
                                           : (res_b_i.dn - res_a_i.dn);
    both_ok_c = res_a_i.ok && res_b_i.ok;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      invalid_q  <= !both_ok_c;
      distance_q <= both_ok_c ? diff_c[DIST_W-1:0] : '0;
    end
  end

  assign invalid_o  = invalid_q;
  assign distance_o = distance_q;

endmodule

@@ hdl/calendar_date_distance_unit.sv @@
// Pipeline: 4 lane stages and 1 merge stage from input beat to result beat.
// Throughput: one date pair per cycle while the output is not stalled; both lanes resolve a date each such cycle.
// A stalled output freezes the whole pipeline; input ready follows the output slot.
// Reset clears the stage valid bits and the output valid; payload is not reset.
// Top level: two date lanes in parallel and a merge stage for the distance.
module calendar_date_distance_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dcd_in_if.sink       in_i,
  dcd_out_if.source    out_o
);
  import dcd_pkg::*;

  logic                   en;
  logic [LANE_STAGES-1:0] vld_q;
  logic                   out_valid_q;
  date_t                  date_a, date_b;
  lane_res_t              res_a, res_b;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    date_a.nth     = in_i.op[OP_NTH_A_BIT];
    date_a.year    = in_i.year_a;
    date_a.month   = in_i.month_a;
    date_a.day     = in_i.day_a;
    date_a.weekday = in_i.weekday_a;
    date_b.nth     = in_i.op[OP_NTH_B_BIT];
    date_b.year    = in_i.year_b;
    date_b.month   = in_i.month_b;
    date_b.day     = in_i.day_b;
    date_b.weekday = in_i.weekday_b;
  end

  dcd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .date_i (date_a),
    .res_o  (res_a)
  );

  dcd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .date_i (date_b),
    .res_o  (res_b)
  );

  dcd_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (en),
    .res_a_i    (res_a),
    .res_b_i    (res_b),
    .invalid_o  (out_o.invalid),
    .distance_o (out_o.day_distance)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LANE_STAGES-2:0], in_i.valid};
      out_valid_q <= vld_q[LANE_STAGES-1];
    end
  end

  assign out_o.valid = out_valid_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.invalid |-> out_o.day_distance == '0)
    else $error("invalid beat carries a nonzero distance");

  a_last_stage_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LANE_STAGES-1] && en |=> out_o.valid)
    else $error("lane result lost before output register");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

endmodule
